>>> sv/fpfd_pkg.sv
// ----------------------------------------------------------------------------
// fpfd_pkg
// Shared types and constants of the FSK period frame demodulator.
// ----------------------------------------------------------------------------
package fpfd_pkg;

    localparam int SAMPLE_W = 16;
    localparam int MARGIN_W = 8;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_PERIOD   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_MARGIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_THRESHOLD = 2'd2;

    localparam logic [SAMPLE_W-1:0] ZERO_PERIOD_RST   = 16'd454;
    localparam logic [MARGIN_W-1:0] START_MARGIN_RST  = 8'd20;
    localparam logic [SAMPLE_W-1:0] BIT_THRESHOLD_RST = 16'd630;

    typedef logic [SAMPLE_W-1:0] t_sample;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FRAME,
        ST_DECODE,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic shift_sample;
        logic shift_pair;
    } t_cell_ctrl;

    typedef struct packed {
        logic start;
        logic step;
    } t_dec_ctrl;

endpackage

>>> sv/fpfd_cell.sv
// ----------------------------------------------------------------------------
// fpfd_cell
// One link of the sample chain: holds one sample pair and shifts it by one
// sample while collecting or by one pair while decoding.
// ----------------------------------------------------------------------------
module fpfd_cell (
    input  logic               i_clk,
    input  fpfd_pkg::t_cell_ctrl i_ctrl,
    input  fpfd_pkg::t_sample  i_nb_lo,
    input  fpfd_pkg::t_sample  i_nb_hi,
    output fpfd_pkg::t_sample  o_lo,
    output fpfd_pkg::t_sample  o_hi
);
    import fpfd_pkg::*;

    t_sample r_lo;
    t_sample r_hi;

    always_ff @(posedge i_clk) begin
        priority if (i_ctrl.shift_sample) begin
            r_lo <= r_hi;
            r_hi <= i_nb_lo;
        end else if (i_ctrl.shift_pair) begin
            r_lo <= i_nb_lo;
            r_hi <= i_nb_hi;
        end
    end

    assign o_lo = r_lo;
    assign o_hi = r_hi;

endmodule

>>> sv/fpfd_decoder.sv
// ----------------------------------------------------------------------------
// fpfd_decoder
// Averages the sample pair at the head of the chain, one pair per cycle while
// stepped, and assembles the frame word bit by bit.
// ----------------------------------------------------------------------------
module fpfd_decoder #(
    parameter int FRAME_BITS = 11
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  fpfd_pkg::t_dec_ctrl   i_ctrl,
    input  fpfd_pkg::t_sample     i_lo,
    input  fpfd_pkg::t_sample     i_hi,
    input  fpfd_pkg::t_sample     i_thr,
    output logic [FRAME_BITS-1:0] o_word
);
    import fpfd_pkg::*;

    logic                  r_first;
    logic                  r_prev_eq;
    logic [FRAME_BITS-1:0] r_word;
    logic [SAMPLE_W:0]     w_sum;
    t_sample               w_avg;
    logic                  w_one;

    assign w_sum = {1'b0, i_lo} + {1'b0, i_hi};
    assign w_avg = w_sum[SAMPLE_W:1];
    assign w_one = (w_avg > i_thr) && (r_first || !r_prev_eq);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first   <= 1'b1;
            r_prev_eq <= 1'b0;
        end else if (i_ctrl.start) begin
            r_first   <= 1'b1;
        end else if (i_ctrl.step) begin
            r_first   <= 1'b0;
            r_prev_eq <= (w_avg == i_thr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.step) begin
            r_word <= {w_one, r_word[FRAME_BITS-1:1]};
        end
    end

    assign o_word = r_word;

endmodule

>>> sv/fsk_period_frame_demodulator_core.sv
// ----------------------------------------------------------------------------
// fsk_period_frame_demodulator_core
// After the last tick the frame word passes ST_DECODE and ST_OUT into the output register.
// Throughput: one tick per cycle while collecting; after the last tick of a
// frame the input stalls while the sample chain shifts one pair per cycle
// into the averager and then while the output register is loaded, held
// longer while the output register still carries an untaken word.
// Reset clears control state and the configuration to its defaults.
// ----------------------------------------------------------------------------
module fsk_period_frame_demodulator_core #(
    parameter int FRAME_BITS = 11
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [15:0]                   i_s_axis_tdata,  // measured_period
    input  logic                          i_s_axis_tuser,  // new_period
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [((FRAME_BITS+7)/8)*8-1:0] o_m_axis_tdata, // frame_bits, zero pad
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [fpfd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]                   i_cfg_data
);
    import fpfd_pkg::*;

    localparam int NumSamples = 2 * FRAME_BITS;
    localparam int SampleCntW = $clog2(NumSamples);
    localparam int BitCntW    = $clog2(FRAME_BITS);
    localparam int TdataW     = ((FRAME_BITS + 7) / 8) * 8;

    t_sample               r_zero_period;
    logic [MARGIN_W-1:0]   r_start_margin;
    t_sample               r_bit_threshold;

    t_state                r_state;
    t_state                n_state;
    logic [SampleCntW-1:0] r_count;
    logic [SampleCntW-1:0] n_count;
    logic [BitCntW-1:0]    r_bcnt;
    logic [BitCntW-1:0]    n_bcnt;
    t_sample               r_last;
    logic                  r_m_valid;
    logic                  n_m_valid;
    logic [TdataW-1:0]     r_m_data;

    logic                  w_accept;
    t_sample               w_period;
    logic                  w_near;
    logic                  w_store;
    t_sample               w_value;
    logic                  w_load;
    t_cell_ctrl            w_cell_ctrl;
    t_dec_ctrl             w_dec_ctrl;
    logic [FRAME_BITS-1:0] w_word;
    t_sample               w_lo [FRAME_BITS];
    t_sample               w_hi [FRAME_BITS];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_period   <= ZERO_PERIOD_RST;
            r_start_margin  <= START_MARGIN_RST;
            r_bit_threshold <= BIT_THRESHOLD_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ZERO_PERIOD:   r_zero_period   <= i_cfg_data;
                CFG_START_MARGIN:  r_start_margin  <= i_cfg_data[MARGIN_W-1:0];
                CFG_BIT_THRESHOLD: r_bit_threshold <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == ST_IDLE) || (r_state == ST_FRAME);
    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign w_period = {i_s_axis_tdata[SAMPLE_W-2:0], 1'b0};

    assign w_near =
        ({1'b0, w_period} <= ({1'b0, r_zero_period} + {9'd0, r_start_margin})) &&
        (({1'b0, w_period} + {9'd0, r_start_margin}) >= {1'b0, r_zero_period});

    assign w_value = i_s_axis_tuser ? w_period : r_last;

    always_comb begin
        w_store = 1'b0;
        if (w_accept) begin
            if (r_state == ST_FRAME) begin
                w_store = 1'b1;
            end else begin
                w_store = i_s_axis_tuser && w_near;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= '0;
        end else if (w_accept && i_s_axis_tuser) begin
            r_last <= w_period;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_bcnt    <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_bcnt    <= n_bcnt;
            r_m_valid <= n_m_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_bcnt      = r_bcnt;
        n_m_valid   = r_m_valid && !i_m_axis_tready;
        w_load      = 1'b0;
        w_cell_ctrl = '0;
        w_dec_ctrl  = '0;
        unique case (r_state)
            ST_IDLE, ST_FRAME: begin
                if (w_store) begin
                    w_cell_ctrl.shift_sample = 1'b1;
                    if (r_count == SampleCntW'(NumSamples - 1)) begin
                        n_count          = '0;
                        n_bcnt           = '0;
                        n_state          = ST_DECODE;
                        w_dec_ctrl.start = 1'b1;
                    end else begin
                        n_count = r_count + 1'b1;
                        n_state = ST_FRAME;
                    end
                end
            end
            ST_DECODE: begin
                w_cell_ctrl.shift_pair = 1'b1;
                w_dec_ctrl.step        = 1'b1;
                n_bcnt                 = r_bcnt + 1'b1;
                if (r_bcnt == BitCntW'(FRAME_BITS - 1)) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!r_m_valid || i_m_axis_tready) begin
                    w_load    = 1'b1;
                    n_m_valid = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_m_data <= TdataW'(w_word);
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;

    genvar k;
    generate
        for (k = 0; k < FRAME_BITS; k++) begin : g_chain
            if (k == FRAME_BITS - 1) begin : g_tail
                fpfd_cell u_cell (
                    .i_clk   (i_clk),
                    .i_ctrl  (w_cell_ctrl),
                    .i_nb_lo (w_value),
                    .i_nb_hi ('0),
                    .o_lo    (w_lo[k]),
                    .o_hi    (w_hi[k])
                );
            end else begin : g_body
                fpfd_cell u_cell (
                    .i_clk   (i_clk),
                    .i_ctrl  (w_cell_ctrl),
                    .i_nb_lo (w_lo[k+1]),
                    .i_nb_hi (w_hi[k+1]),
                    .o_lo    (w_lo[k]),
                    .o_hi    (w_hi[k])
                );
            end
        end
    endgenerate

    fpfd_decoder #(
        .FRAME_BITS (FRAME_BITS)
    ) u_decoder (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_dec_ctrl),
        .i_lo    (w_lo[0]),
        .i_hi    (w_hi[0]),
        .i_thr   (r_bit_threshold),
        .o_word  (w_word)
    );

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= SampleCntW'(NumSamples - 1))
        else $error("sample count out of range");

    a_idle_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_count == '0))
        else $error("sample count not cleared while idle");

    a_decode_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DECODE && r_bcnt == BitCntW'(FRAME_BITS - 1)) |=>
        (r_state == ST_OUT))
        else $error("decode did not end after the last pair");

    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> ($past(r_state) == ST_OUT))
        else $error("output raised outside the load step");

    a_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_store && r_count == SampleCntW'(NumSamples - 1)) |=>
        (r_state == ST_DECODE && !o_s_axis_tready))
        else $error("full frame did not start decoding");
`endif

endmodule

>>> sim/fsk_period_frame_demodulator_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fsk_period_frame_demodulator_core_test
// Streams half-bit ticks into the demodulator, predicts every decoded frame
// word from a cycle-free model of start detection, sample repeat and pair
// averaging, and compares each delivered word in order. Runs a directed
// frame, then random frames and noise under several register settings,
// with random gaps on both streams and one long output hold-off.
// ----------------------------------------------------------------------------
module fsk_period_frame_demodulator_core_test;
    import fpfd_pkg::*;

    localparam int FRAME_BITS  = 11;
    localparam int NUM_SAMPLES = 2 * FRAME_BITS;
    localparam int OUT_W       = ((FRAME_BITS + 7) / 8) * 8;
    localparam int PHASE_TICKS = 280;

    typedef struct {
        bit      fresh;
        t_sample raw;
    } period_tick_t;

    logic                 i_clk           = 1'b0;
    logic                 i_rst_n         = 1'b0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    logic [15:0]          i_s_axis_tdata  = '0;  // measured_period
    logic                 i_s_axis_tuser  = 1'b0; // new_period
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    logic [OUT_W-1:0]     o_m_axis_tdata;         // frame_bits, zero pad
    logic                 i_cfg_valid     = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index     = '0;
    logic [15:0]          i_cfg_data      = '0;

    fsk_period_frame_demodulator_core #(
        .FRAME_BITS(FRAME_BITS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tuser (i_s_axis_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    period_tick_t          tick_q[$];
    logic [FRAME_BITS-1:0] frame_q[$];
    int                    ticks_queued  = 0;
    int                    ticks_taken   = 0;
    int                    mismatch_cnt  = 0;
    bit                    tick_fired    = 1'b0;
    bit                    idle_on       = 1'b1;
    int                    gap_left      = 0;
    int                    stall_left    = 0;
    int                    hold_request  = 0;
    bit                    long_hold     = 1'b0;

    // demodulator state and register copies
    t_sample               zero_r   = ZERO_PERIOD_RST;
    logic [MARGIN_W-1:0]   margin_r = START_MARGIN_RST;
    t_sample               thresh_r = BIT_THRESHOLD_RST;
    bit                    dm_active = 1'b0;
    int                    dm_count  = 0;
    t_sample               dm_last   = '0;
    t_sample               dm_samples[NUM_SAMPLES];

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    task automatic report_mismatch(string msg);
        $display("%0t ns  %s", $time, msg);
        mismatch_cnt++;
    endtask

    function automatic void demod_step(bit fresh, t_sample raw);
        t_sample               p;
        t_sample               v;
        t_sample               avg;
        t_sample               prev_avg;
        logic [16:0]           sum;
        logic [FRAME_BITS-1:0] word;
        bit                    keep;
        int                    k;
        p    = {raw[14:0], 1'b0};
        v    = p;
        keep = 1'b0;
        if (fresh) begin
            dm_last = p;
            if (dm_active) begin
                keep = 1'b1;
            end else if (int'(p) <= int'(zero_r) + int'(margin_r) &&
                         int'(p) + int'(margin_r) >= int'(zero_r)) begin
                dm_active = 1'b1;
                keep      = 1'b1;
            end
        end else if (dm_active) begin
            keep = 1'b1;
            v    = dm_last;
        end
        if (keep) begin
            if (dm_count < NUM_SAMPLES) dm_samples[dm_count] = v;
            dm_count++;
        end
        if (dm_active && dm_count >= NUM_SAMPLES) begin
            word     = '0;
            prev_avg = '0;
            for (k = 0; k < FRAME_BITS; k++) begin
                sum = {1'b0, dm_samples[2*k]} + {1'b0, dm_samples[2*k+1]};
                avg = sum[16:1];
                if (avg > thresh_r && !(k > 0 && prev_avg == thresh_r)) word[k] = 1'b1;
                prev_avg = avg;
            end
            frame_q.push_back(word);
            dm_active = 1'b0;
            dm_count  = 0;
        end
    endfunction

    // tick sender
    always @(negedge i_clk) begin : tick_driver
        period_tick_t nxt;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (!i_s_axis_tvalid || tick_fired) begin
            tick_fired = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
                i_s_axis_tvalid <= 1'b0;
            end else if (tick_q.size() != 0) begin
                nxt = tick_q.pop_front();
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata  <= nxt.raw;
                i_s_axis_tuser  <= nxt.fresh;
                if (idle_on && $urandom_range(0, 7) == 0) gap_left = $urandom_range(1, 12);
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // frame receiver
    always @(negedge i_clk) begin
        if (!i_rst_n || long_hold) begin
            i_m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_m_axis_tready <= 1'b0;
        end else begin
            if (idle_on && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 12);
            i_m_axis_tready <= 1'b1;
        end
    end

    initial begin : rx_hold
        int n;
        forever begin
            @(posedge i_clk);
            if (hold_request > 0) begin
                n            = hold_request;
                hold_request = 0;
                long_hold    = 1'b1;
                repeat (n) @(posedge i_clk);
                long_hold    = 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready) begin
            demod_step(i_s_axis_tuser, i_s_axis_tdata);
            ticks_taken++;
            tick_fired = 1'b1;
        end
    end

    always @(posedge i_clk) begin : frame_check
        logic [FRAME_BITS-1:0] want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (frame_q.size() == 0) begin
                report_mismatch($sformatf("unexpected frame %h", o_m_axis_tdata));
            end else begin
                want = frame_q.pop_front();
                if (o_m_axis_tdata !== OUT_W'(want))
                    report_mismatch($sformatf("frame_bits got %h want %h",
                                              o_m_axis_tdata, OUT_W'(want)));
            end
        end
    end

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_ZERO_PERIOD:   zero_r   = data;
            CFG_START_MARGIN:  margin_r = data[MARGIN_W-1:0];
            CFG_BIT_THRESHOLD: thresh_r = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_config(int z, int m, int t);
        cfg_write(CFG_ZERO_PERIOD, 16'(z));
        cfg_write(CFG_START_MARGIN, 16'(($urandom_range(0, 255) << 8) | m));
        cfg_write(CFG_BIT_THRESHOLD, 16'(t));
    endtask

    task automatic push_raw(bit fresh, t_sample raw);
        period_tick_t tk;
        tk.fresh = fresh;
        tk.raw   = raw;
        tick_q.push_back(tk);
        ticks_queued++;
    endtask

    // drop the doubling: bit 15 of the raw period is lost, so randomize it
    task automatic push_period(int p);
        t_sample pv;
        pv = t_sample'(p);
        push_raw(1'b1, {1'($urandom_range(0, 1)), pv[15:1]});
    endtask

    function automatic int start_period();
        int lo;
        int hi;
        lo = int'(zero_r) - int'(margin_r);
        hi = int'(zero_r) + int'(margin_r);
        if (lo < 0) lo = 0;
        if (hi > 65535) hi = 65535;
        lo = (lo + 1) & ~1;
        if (lo > hi) return $urandom_range(0, 65535);
        return 2 * $urandom_range(lo / 2, hi / 2);
    endfunction

    function automatic int tone_period(int tone);
        if (tone == 0) return $urandom_range(0, int'(thresh_r));
        if (thresh_r == 16'hFFFF) return $urandom_range(0, 65535);
        return $urandom_range(int'(thresh_r) + 1, 65535);
    endfunction

    task automatic queue_frame();
        int tones[FRAME_BITS];
        int k;
        int s;
        int r;
        for (k = 0; k < FRAME_BITS; k++) begin
            r = $urandom_range(0, 5);
            tones[k] = (r < 3) ? 0 : (r < 5) ? 1 : 2;
        end
        push_period(start_period());
        for (s = 1; s < NUM_SAMPLES; s++) begin
            k = s / 2;
            if (tones[k] == 2) begin
                // pair whose average lands exactly on the threshold
                if (thresh_r[0]) push_period(s[0] ? int'(thresh_r) + 1 : int'(thresh_r) - 1);
                else push_period(int'(thresh_r));
            end else if ($urandom_range(0, 3) != 0) begin
                push_period(tone_period(tones[k]));
            end else begin
                push_raw(1'b0, t_sample'($urandom));
            end
        end
    endtask

    task automatic queue_random(int budget);
        int made;
        int n;
        made = 0;
        while (made < budget) begin
            if ($urandom_range(0, 9) < 8) begin
                queue_frame();
                made += NUM_SAMPLES;
            end else begin
                n = $urandom_range(1, 8);
                repeat (n) push_raw(1'($urandom_range(0, 1)), t_sample'($urandom));
                made += n;
            end
        end
    endtask

    // hold until every tick is taken, close any open frame, then drain results
    task automatic settle();
        int waited;
        while (ticks_taken != ticks_queued) @(negedge i_clk);
        while (dm_active) begin
            repeat (NUM_SAMPLES - dm_count) push_raw(1'b0, t_sample'($urandom));
            while (ticks_taken != ticks_queued) @(negedge i_clk);
        end
        waited = 0;
        while (frame_q.size() != 0 && waited < 5000) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (FRAME_BITS + 6) @(negedge i_clk);
    endtask

    initial begin : stimulus
        int k;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed frame at reset settings
        push_raw(1'b0, 16'hFFFF);
        push_raw(1'b1, 16'h0000);
        push_raw(1'b1, 16'hFFFF);
        push_raw(1'b1, 16'h8000 | 16'd227);
        push_raw(1'b1, 16'h7FFF);
        push_raw(1'b1, 16'd315);
        push_raw(1'b1, 16'd315);
        push_raw(1'b1, 16'h7FFF);
        push_raw(1'b0, 16'h0000);
        push_raw(1'b0, 16'hFFFF);
        push_raw(1'b0, 16'h1234);
        for (k = 4; k < FRAME_BITS; k++) begin
            push_raw(1'b1, k[0] ? 16'h7FFF : 16'h8000);
            push_raw(k >= 7, k[0] ? 16'hFFFF : 16'h0000);
        end
        settle();

        set_config(0, 255, 0);
        queue_random(PHASE_TICKS);
        settle();

        set_config(65535, 255, 65535);
        queue_random(PHASE_TICKS);
        settle();

        set_config(1000, 0, 630);
        queue_random(PHASE_TICKS);
        settle();

        set_config(454, 20, 40000);
        queue_random(PHASE_TICKS);
        settle();

        repeat (2) begin
            set_config($urandom_range(0, 65535), $urandom_range(0, 255),
                       $urandom_range(0, 65535));
            queue_random(PHASE_TICKS);
            settle();
        end

        // block the output while frames keep coming
        set_config(454, 20, 630);
        @(negedge i_clk);
        hold_request = 400;
        repeat (5) queue_frame();
        queue_random(PHASE_TICKS / 2);
        settle();

        idle_on = 1'b0;
        set_config($urandom_range(400, 500), $urandom_range(10, 40), $urandom_range(500, 700));
        queue_random(PHASE_TICKS);
        settle();

        if (frame_q.size() != 0)
            report_mismatch($sformatf("%0d frames never delivered", frame_q.size()));
        if (mismatch_cnt == 0) begin
            $display("fsk_period_frame_demodulator_core_test: done, clean");
        end else begin
            $display("fsk_period_frame_demodulator_core_test: done, errors");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("fsk_period_frame_demodulator_core_test: done, errors");
        $finish;
    end

endmodule
